### src/htlp_pkg.sv
// Shared types, codes and helpers for the linear-probing hash table.
// No dependencies; every other file in this block imports it.

package htlp_pkg;

  // Field widths fixed by the interface.
  localparam int KEY_BYTES = 4;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int AGE_W     = 7;
  localparam int SLOT_W    = 5;
  localparam int COUNT_W   = 6;
  localparam int SUM_W     = 8 + $clog2(KEY_BYTES + 1);

  // Default table depth.
  localparam int DEF_TABLE_SIZE = 32;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_REJECTED  = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HOME,
    S_PROBE
  } state_t;

  // Keep the name up to its first zero byte and clear every byte after it.
  function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] out;
    logic             ended;
    out   = '0;
    ended = 1'b0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (raw[8*b +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        out[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return out;
  endfunction

endpackage

### src/htlp_home.sv
// Home slot unit: byte sum of the key reduced modulo the table size.
// Depends on htlp_pkg. One register stage; the slot is valid in the cycle
// after the key is presented.

module htlp_home #(
  parameter int TABLE_SIZE = htlp_pkg::DEF_TABLE_SIZE
) (
  input  logic                                 clk,
  input  logic [htlp_pkg::KEY_W-1:0]           key,
  output logic [$clog2(TABLE_SIZE)-1:0]        home
);
  import htlp_pkg::*;

  localparam int IW     = $clog2(TABLE_SIZE);
  localparam int SH     = SUM_W + 1;
  localparam int RECIP  = (1 << SH) / TABLE_SIZE;
  localparam int RW     = $clog2(RECIP + 1);
  localparam int PW     = SUM_W + RW;
  localparam int DW     = SUM_W + IW + 1;

  logic [SUM_W-1:0] sum_c;
  logic [PW-1:0]    prod_c;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] quot;
  logic [DW-1:0]    rem_c;
  logic [DW-1:0]    rem_fix;

  // Byte sum of the key.
  always_comb begin
    sum_c = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      sum_c = sum_c + SUM_W'(key[8*b +: 8]);
    end
  end

  // Quotient estimate by reciprocal multiply; it is exact or one short.
  assign prod_c = PW'(sum_c) * PW'(RECIP);

  always_ff @(posedge clk) begin
    sum  <= sum_c;
    quot <= SUM_W'(prod_c >> SH);
  end

  // Remainder with a single correction step.
  assign rem_c   = DW'(sum) - DW'(quot) * DW'(TABLE_SIZE);
  assign rem_fix = (rem_c >= DW'(TABLE_SIZE)) ? rem_c - DW'(TABLE_SIZE) : rem_c;
  assign home    = rem_fix[IW-1:0];

endmodule

### src/hash_table_linear_probe_unit.sv
// Top level of the open-addressed hash table with linear probing.
// Depends on htlp_pkg and htlp_home. Holds the slot memory and the probe
// controller.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  request  | start / busy         | operation, name_key, age_value
//  result   | done (one cycle)     | status, slot_index, age_found, entry_count
//
// An operation passes through S_HASH, S_HOME and S_PROBE from its transfer to
// done, where S_PROBE checks k slots (1 to TABLE_SIZE), one memory read per
// cycle through the single read port; an empty name is rejected in S_HASH.
// After reset the memory is swept clear, one slot a cycle, through all
// TABLE_SIZE slots, with busy high. A result is shown for one cycle with
// done; the receiver cannot stall it.

module hash_table_linear_probe_unit #(
  parameter int TABLE_SIZE = htlp_pkg::DEF_TABLE_SIZE
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic [htlp_pkg::KEY_W-1:0]          name_key,
  input  logic [htlp_pkg::AGE_W-1:0]          age_value,
  output logic                                done,
  output logic [1:0]                          status,
  output logic [htlp_pkg::SLOT_W-1:0]         slot_index,
  output logic [htlp_pkg::AGE_W-1:0]          age_found,
  output logic [htlp_pkg::COUNT_W-1:0]        entry_count
);
  import htlp_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int MW = KEY_W + AGE_W;

  // Slot memory: key in the upper bits, age in the lower bits.
  logic [MW-1:0] mem [TABLE_SIZE];
  logic [MW-1:0] rdata;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;

  state_t        state;
  state_t        state_next;
  logic          op;
  logic [KEY_W-1:0] key;
  logic [AGE_W-1:0] age;
  logic [IW-1:0] issue_idx;
  logic [IW-1:0] issue_idx_next;
  logic [IW-1:0] chk_idx;
  logic          chk_valid;
  logic [CW-1:0] chk_cnt;
  logic [CW-1:0] count;
  logic [IW-1:0] home;

  logic [KEY_W-1:0] rd_key;
  logic [AGE_W-1:0] rd_age;
  logic          slot_free;
  logic          slot_match;
  logic          last_slot;
  logic          finish;
  status_t       res_status;
  logic [IW-1:0] res_slot;
  logic [AGE_W-1:0] res_age;
  logic          count_inc;

  htlp_home #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_home (
    .clk  (clk),
    .key  (key),
    .home (home)
  );

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[issue_idx];
  end

  assign rd_key     = rdata[MW-1:AGE_W];
  assign rd_age     = rdata[AGE_W-1:0];
  assign slot_free  = (rd_key[7:0] == 8'd0);
  assign slot_match = (rd_key == key);
  assign last_slot  = (chk_cnt == CW'(TABLE_SIZE - 1));
  assign issue_idx_next = (issue_idx == IW'(TABLE_SIZE - 1)) ? '0 : issue_idx + 1'b1;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (issue_idx == IW'(TABLE_SIZE - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_HASH;
      end
      S_HASH: begin
        state_next = (key[7:0] == 8'd0) ? S_IDLE : S_HOME;
      end
      S_HOME: begin
        state_next = S_PROBE;
      end
      S_PROBE: begin
        if (finish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output and datapath decisions for the current state.
  always_comb begin
    busy       = (state != S_IDLE);
    mem_we     = 1'b0;
    mem_waddr  = chk_idx;
    mem_wdata  = {key, age};
    finish     = 1'b0;
    res_status = ST_REJECTED;
    res_slot   = '0;
    res_age    = '0;
    count_inc  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = issue_idx;
        mem_wdata = '0;
      end
      S_HASH: begin
        // An empty name is rejected without probing.
        if (key[7:0] == 8'd0) finish = 1'b1;
      end
      S_PROBE: begin
        if (chk_valid) begin
          if (op == OP_INSERT) begin
            if (slot_free) begin
              mem_we     = 1'b1;
              finish     = 1'b1;
              count_inc  = 1'b1;
              res_status = ST_INSERTED;
              res_slot   = chk_idx;
            end else if (last_slot) begin
              finish = 1'b1;
            end
          end else begin
            if (slot_free) begin
              finish     = 1'b1;
              res_status = ST_NOT_FOUND;
            end else if (slot_match) begin
              finish     = 1'b1;
              res_status = ST_FOUND;
              res_slot   = chk_idx;
              res_age    = rd_age;
            end else if (last_slot) begin
              finish     = 1'b1;
              res_status = ST_NOT_FOUND;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      issue_idx <= '0;
      chk_valid <= 1'b0;
      count     <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (count_inc) count <= count + 1'b1;
      unique case (state)
        S_CLEAR: issue_idx <= issue_idx_next;
        S_HOME: begin
          issue_idx <= home;
          chk_valid <= 1'b0;
        end
        S_PROBE: begin
          issue_idx <= issue_idx_next;
          chk_valid <= 1'b1;
        end
        default: chk_valid <= 1'b0;
      endcase
    end
  end

  // Request capture, probe bookkeeping and result registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op  <= operation;
      key <= canon_key(name_key);
      age <= age_value;
    end
    chk_idx <= issue_idx;
    if (state == S_HOME) begin
      chk_cnt <= '0;
    end else if (state == S_PROBE && chk_valid) begin
      chk_cnt <= chk_cnt + 1'b1;
    end
    if (finish) begin
      status     <= res_status;
      slot_index <= SLOT_W'(res_slot);
      age_found  <= res_age;
    end
  end

  assign entry_count = COUNT_W'(count);

  // The occupancy never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_SIZE))
    else $error("occupancy count exceeds table size");

  // A result lasts exactly one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // A successful insert adds exactly one entry.
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_INSERTED) |-> count == $past(count) + 1'b1)
    else $error("insert did not add one entry");

  // A failed or rejected operation reports slot zero and age zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_NOT_FOUND || status == ST_REJECTED))
      |-> (slot_index == '0 && age_found == '0))
    else $error("miss result carries a slot or an age");

  // An accepted request makes the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

endmodule

### tb/testbench.sv
// Self-checking testbench for hash_table_linear_probe_unit: directed rows, then random
// insert and search traffic, checked against a shadow copy of the slot table.
// Depends on htlp_pkg and the RTL under src.
`timescale 1ns / 100ps

module testbench;
  import htlp_pkg::*;

  localparam int TABLE_DEPTH = DEF_TABLE_SIZE;
  localparam int DIRECTED_ROWS = 22;
  localparam int PHASE_ITEMS = 160;
  localparam int SETTLE_CYCLES = 3 * TABLE_DEPTH;

  // One result as the block reports it.
  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [AGE_W-1:0]     age;
    logic [COUNT_W-1:0]   count;
  } answer_t;

  // One directed request, with a hand-written answer where it is obvious.
  typedef struct packed {
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [AGE_W-1:0]  age;
    logic              pinned;
    answer_t           answer;
  } request_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                operation;
  logic [KEY_W-1:0]    name_key;
  logic [AGE_W-1:0]    age_value;
  logic                done;
  logic [1:0]          status;
  logic [SLOT_W-1:0]   slot_index;
  logic [AGE_W-1:0]    age_found;
  logic [COUNT_W-1:0]  entry_count;

  // Shadow of the slot table and the answers still owed by the block.
  logic [KEY_W-1:0]    shadow_keys [TABLE_DEPTH];
  logic [AGE_W-1:0]    shadow_ages [TABLE_DEPTH];
  int                  shadow_count;
  answer_t             answers_due [$];
  logic [KEY_W-1:0]    stored_names [$];
  logic                pinned_valid;
  answer_t             pinned_answer;
  int                  errors;
  request_row_t        directed_rows [DIRECTED_ROWS];

  hash_table_linear_probe_unit #(
    .TABLE_SIZE(TABLE_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .name_key    (name_key),
    .age_value   (age_value),
    .done        (done),
    .status      (status),
    .slot_index  (slot_index),
    .age_found   (age_found),
    .entry_count (entry_count)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cut the name at its first zero byte, then apply one operation to the shadow table.
  function automatic answer_t table_step(input logic op, input logic [KEY_W-1:0] raw,
                                         input logic [AGE_W-1:0] age);
    answer_t          a;
    logic [KEY_W-1:0] name;
    int               sum;
    int               home;
    int               idx;
    name = '0;
    sum = 0;
    a = '{ST_REJECTED, '0, '0, '0};
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (raw[8*b +: 8] == 8'd0) break;
      name[8*b +: 8] = raw[8*b +: 8];
      sum += int'(raw[8*b +: 8]);
    end
    home = sum % TABLE_DEPTH;
    if (name[7:0] != 8'd0) begin
      if (op == OP_INSERT) begin
        for (int n = 0; n < TABLE_DEPTH; n++) begin
          idx = (home + n) % TABLE_DEPTH;
          if (shadow_keys[idx][7:0] == 8'd0) begin
            shadow_keys[idx] = name;
            shadow_ages[idx] = age;
            shadow_count++;
            a.status = ST_INSERTED;
            a.slot = idx[SLOT_W-1:0];
            break;
          end
        end
      end else begin
        a.status = ST_NOT_FOUND;
        for (int n = 0; n < TABLE_DEPTH; n++) begin
          idx = (home + n) % TABLE_DEPTH;
          if (shadow_keys[idx][7:0] == 8'd0) break;
          if (shadow_keys[idx] == name) begin
            a.status = ST_FOUND;
            a.slot = idx[SLOT_W-1:0];
            a.age = shadow_ages[idx];
            break;
          end
        end
      end
    end
    a.count = shadow_count[COUNT_W-1:0];
    return a;
  endfunction

  // Fill the bytes past the terminating zero with noise; they must not matter.
  function automatic logic [KEY_W-1:0] with_tail_noise(input logic [KEY_W-1:0] name);
    logic [KEY_W-1:0] raw;
    logic [KEY_W-1:0] noise;
    int               len;
    raw = name;
    noise = $urandom;
    len = KEY_BYTES;
    for (int b = KEY_BYTES - 1; b >= 0; b--) begin
      if (name[8*b +: 8] == 8'd0) len = b;
    end
    for (int b = len + 1; b < KEY_BYTES; b++) begin
      raw[8*b +: 8] = noise[8*b +: 8];
    end
    return raw;
  endfunction

  // A fresh name of one to four nonzero bytes.
  function automatic logic [KEY_W-1:0] fresh_name();
    logic [KEY_W-1:0] name;
    int               len;
    name = '0;
    len = $urandom_range(KEY_BYTES, 1);
    for (int b = 0; b < len; b++) begin
      name[8*b +: 8] = 8'($urandom_range(255, 1));
    end
    return name;
  endfunction

  // Result check first, then the transfer taken at this same edge.
  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (!rst) begin
      got = '{status_t'(status), slot_index, age_found, entry_count};
      if (done) begin
        if (answers_due.size() == 0) begin
          $display("%0t: result with none expected: status=%0d slot=%0d age=%0d count=%0d",
                   $time, status, slot_index, age_found, entry_count);
          errors++;
        end else begin
          want = answers_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected status=%0d slot=%0d age=%0d count=%0d",
                     $time, want.status, want.slot, want.age, want.count);
            $display("%0t:          actual   status=%0d slot=%0d age=%0d count=%0d",
                     $time, status, slot_index, age_found, entry_count);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        want = table_step(operation, name_key, age_value);
        if (pinned_valid) want = pinned_answer;
        answers_due.push_back(want);
      end
    end
  end

  // Present one request from the falling edge and hold it until its transfer.
  task automatic offer(input logic op, input logic [KEY_W-1:0] key,
                       input logic [AGE_W-1:0] age, input logic pin, input answer_t ans);
    start <= 1'b1;
    operation <= op;
    name_key <= key;
    age_value <= age;
    pinned_valid <= pin;
    pinned_answer <= ans;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Idle the request side for a random number of cycles, with junk on the payload.
  task automatic idle_some(input int pct);
    while (int'($urandom_range(99)) < pct) begin
      start <= 1'b0;
      name_key <= $urandom;
      age_value <= 7'($urandom);
      @(negedge clk);
    end
  endtask

  // Stop offering until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Stimulus: reset, directed rows, then three random phases.
  initial begin
    int               idle_pct [3];
    int               pick;
    logic             op;
    logic [KEY_W-1:0] key;
    answer_t          none;
    idle_pct = '{0, 73, 35};
    none = '{ST_INSERTED, '0, '0, '0};
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_keys[i] = '0;
      shadow_ages[i] = '0;
    end
    shadow_count = 0;
    errors = 0;
    rst = 1'b1;
    start = 1'b0;
    operation = OP_INSERT;
    name_key = '0;
    age_value = '0;
    pinned_valid = 1'b0;
    pinned_answer = none;

    // Empty table, empty names, extreme keys and ages, then duplicates and wraparound.
    directed_rows[0]  = '{OP_SEARCH, 32'h0000_0041, 7'h7F, 1'b1, '{ST_NOT_FOUND, 5'd0, 7'd0, 6'd0}};
    directed_rows[1]  = '{OP_INSERT, 32'h0000_0000, 7'h7F, 1'b1, '{ST_REJECTED, 5'd0, 7'd0, 6'd0}};
    directed_rows[2]  = '{OP_SEARCH, 32'hFFFF_FF00, 7'h00, 1'b1, '{ST_REJECTED, 5'd0, 7'd0, 6'd0}};
    directed_rows[3]  = '{OP_INSERT, 32'h0000_00FF, 7'h7F, 1'b1, '{ST_INSERTED, 5'd31, 7'd0, 6'd1}};
    directed_rows[4]  = '{OP_INSERT, 32'hFFFF_FFFF, 7'h00, 1'b1, '{ST_INSERTED, 5'd28, 7'd0, 6'd2}};
    directed_rows[5]  = '{OP_SEARCH, 32'h0000_00FF, 7'h00, 1'b1, '{ST_FOUND, 5'd31, 7'h7F, 6'd2}};
    directed_rows[6]  = '{OP_SEARCH, 32'hFFFF_FFFF, 7'h7F, 1'b1, '{ST_FOUND, 5'd28, 7'd0, 6'd2}};
    directed_rows[7]  = '{OP_INSERT, 32'hFFFF_FF00, 7'h03, 1'b1, '{ST_REJECTED, 5'd0, 7'd0, 6'd2}};
    directed_rows[8]  = '{OP_INSERT, 32'h0000_0001, 7'h05, 1'b0, none};
    directed_rows[9]  = '{OP_INSERT, 32'h1234_0001, 7'h09, 1'b0, none};
    directed_rows[10] = '{OP_SEARCH, 32'h55AA_0001, 7'h00, 1'b0, none};
    directed_rows[11] = '{OP_INSERT, 32'h0000_00DF, 7'h2A, 1'b0, none};
    directed_rows[12] = '{OP_SEARCH, 32'h0000_00DF, 7'h00, 1'b0, none};
    directed_rows[13] = '{OP_SEARCH, 32'h0000_003F, 7'h00, 1'b0, none};
    directed_rows[14] = '{OP_SEARCH, 32'h00FF_00FF, 7'h00, 1'b0, none};
    directed_rows[15] = '{OP_SEARCH, 32'hFF00_FFFF, 7'h00, 1'b0, none};
    directed_rows[16] = '{OP_INSERT, 32'h7F00_FFFF, 7'h11, 1'b0, none};
    directed_rows[17] = '{OP_INSERT, 32'h0101_0101, 7'h55, 1'b0, none};
    directed_rows[18] = '{OP_INSERT, 32'h0000_0004, 7'h2B, 1'b0, none};
    directed_rows[19] = '{OP_SEARCH, 32'h0000_0004, 7'h00, 1'b0, none};
    directed_rows[20] = '{OP_SEARCH, 32'h0101_0101, 7'h00, 1'b0, none};
    directed_rows[21] = '{OP_SEARCH, 32'h0000_0301, 7'h00, 1'b0, none};

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].op, directed_rows[i].key, directed_rows[i].age,
            directed_rows[i].pinned, directed_rows[i].answer);
    end
    drain();

    // Mostly searches for stored names; inserts fill the table gradually until it is full.
    foreach (idle_pct[p]) begin
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(99);
        if (pick < 18) begin
          op = OP_INSERT;
          if (stored_names.size() != 0 && $urandom_range(99) < 30)
            key = stored_names[$urandom_range(stored_names.size() - 1)];
          else
            key = fresh_name();
          stored_names.push_back(key);
          key = with_tail_noise(key);
        end else if (pick < 23) begin
          op = 1'($urandom);
          key = {24'($urandom), 8'h00};
        end else begin
          op = OP_SEARCH;
          if (stored_names.size() != 0 && $urandom_range(99) < 75)
            key = with_tail_noise(stored_names[$urandom_range(stored_names.size() - 1)]);
          else
            key = with_tail_noise(fresh_name());
        end
        offer(op, key, 7'($urandom), 1'b0, none);
        idle_some(idle_pct[p]);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
src/htlp_pkg.sv
src/htlp_home.sv
src/hash_table_linear_probe_unit.sv
tb/testbench.sv
